// File: rtl/brsc_pkg.sv
// Package for the buffer record span calculator.
// Holds widths, register indexes, status codes and the divider lane types.
// No dependencies.
package brsc_pkg;

    localparam int IDX_W    = 49;   // record index field width
    localparam int F24_W    = 24;   // byte position and length fields
    localparam int LPOS_W   = 25;   // signed last record position
    localparam int DIV_W    = 50;   // dividend width, one divider cell per bit
    localparam int REM_W    = 24;   // remainder and divisor width
    localparam int N_LANE   = 4;    // divisions carried side by side
    localparam int WIDE_W   = 57;   // wide index before saturation
    localparam int CFG_W    = 24;   // configuration write data width
    localparam int OFFSET_BITS_DEF = 49;

    // Divider lanes
    localparam int LANE_FIRST = 0;  // byte location / record size
    localparam int LANE_LAST  = 1;  // end byte location / record size
    localparam int LANE_PER   = 2;  // buffer size / record size
    localparam int LANE_BLK   = 3;  // block number / blocks per buffer

    // Configuration register indexes
    localparam logic [2:0] REG_RECORD_SIZE = 3'd0;
    localparam logic [2:0] REG_BLOCK_SIZE  = 3'd1;
    localparam logic [2:0] REG_BUFFER_SIZE = 3'd2;
    localparam logic [2:0] REG_BLOCKS_PER  = 3'd3;
    localparam logic [2:0] REG_ALIGN_MODE  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // One division in flight: dividend bits shift out on the left while
    // quotient bits shift in on the right.
    typedef struct packed {
        logic [DIV_W-1:0] dq;
        logic [REM_W-1:0] rem;
    } lane_t;

    typedef lane_t [N_LANE-1:0] lanes_t;

    // What one divider cell hands to the next
    typedef struct packed {
        logic   valid;
        lanes_t lane;
    } cell_t;

endpackage

// File: rtl/brsc_front.sv
// Front end: byte location of the buffer start and of its last byte.
// Depends on brsc_pkg.
module brsc_front
    import brsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       block_number,
    input  logic [16:0]       block_size,
    input  logic [REM_W-1:0]  buffer_size,
    output cell_t             out
);

    logic              v1_reg;
    logic [48:0]       prod_reg;
    logic [31:0]       loc1_reg;
    logic              v2_reg;
    logic [DIV_W-1:0]  byteloc_reg;
    logic [DIV_W-1:0]  endloc_reg;
    logic [31:0]       loc2_reg;
    logic [DIV_W-1:0]  endloc_next;

    // Valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign endloc_next = DIV_W'(prod_reg) + DIV_W'(buffer_size) - DIV_W'(1);

    // Multiply first, then form the end location
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= 49'(block_number) * 49'(block_size);
            loc1_reg    <= block_number;
            byteloc_reg <= DIV_W'(prod_reg);
            endloc_reg  <= endloc_next;
            loc2_reg    <= loc1_reg;
        end
    end

    // Load the four divider lanes
    always_comb
    begin
        out.valid                = v2_reg;
        out.lane[LANE_FIRST].dq  = byteloc_reg;
        out.lane[LANE_FIRST].rem = '0;
        out.lane[LANE_LAST].dq   = endloc_reg;
        out.lane[LANE_LAST].rem  = '0;
        out.lane[LANE_PER].dq    = DIV_W'(buffer_size);
        out.lane[LANE_PER].rem   = '0;
        out.lane[LANE_BLK].dq    = DIV_W'(loc2_reg);
        out.lane[LANE_BLK].rem   = '0;
    end

endmodule

// File: rtl/brsc_div_cell.sv
// One restoring divider cell: one quotient bit for each lane per item.
// Depends on brsc_pkg.
module brsc_div_cell
    import brsc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [N_LANE-1:0][REM_W-1:0]  divisor,
    input  cell_t                         in,
    output cell_t                         out
);

    logic   valid_reg;
    lanes_t lane_reg;
    lanes_t lane_next;

    // Shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        logic [REM_W:0]   trial;
        logic [REM_W+1:0] diff;
        logic             ge;
        for (int i = 0; i < N_LANE; i++)
        begin
            trial = {in.lane[i].rem, in.lane[i].dq[DIV_W-1]};
            diff  = {1'b0, trial} - {2'b00, divisor[i]};
            ge    = !diff[REM_W+1];
            lane_next[i].rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            lane_next[i].dq  = {in.lane[i].dq[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign out.valid = valid_reg;
    assign out.lane  = lane_reg;

endmodule

// File: rtl/brsc_back.sv
// Back end: derives the record span from quotients and remainders,
// saturates indexes and holds the output register. Depends on brsc_pkg.
module brsc_back
    import brsc_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cell_t              in,
    input  logic [REM_W-1:0]   record_size,
    input  logic [REM_W-1:0]   buffer_size,
    input  logic               align_mode,
    output logic               out_valid,
    output logic [IDX_W-1:0]   first_record,
    output logic [IDX_W-1:0]   last_record,
    output logic [IDX_W-1:0]   first_full_record,
    output logic [IDX_W-1:0]   last_full_record,
    output logic [F24_W-1:0]   first_record_pos,
    output logic [F24_W-1:0]   boundary_offset,
    output logic [F24_W-1:0]   last_record_len,
    output logic [LPOS_W-1:0]  last_record_pos,
    output logic [1:0]         status
);

    localparam int LimBits = (OFFSET_BITS < IDX_W) ? OFFSET_BITS : IDX_W;
    localparam logic [WIDE_W-1:0] Limit = (WIDE_W'(1) << LimBits) - WIDE_W'(1);

    // Stage one registers
    logic               v1_reg;
    logic [WIDE_W-1:0]  nfirst_reg, nlast_reg, nffull_reg, nlfull_reg;
    logic [F24_W-1:0]   fpos_reg, boff_reg, llen_reg;
    logic [LPOS_W-1:0]  nlpos_reg;
    logic [F24_W-1:0]   per_reg;
    logic [55:0]        afirst_reg;
    logic [47:0]        alpos_reg;

    // Stage one logic
    logic [REM_W-1:0]   ra, rb;
    logic [DIV_W-1:0]   qa, qb;
    logic [F24_W-1:0]   llen_n, per_n;
    logic [WIDE_W-1:0]  lfull_n;

    always_comb
    begin
        qa     = in.lane[LANE_FIRST].dq;
        ra     = in.lane[LANE_FIRST].rem;
        qb     = in.lane[LANE_LAST].dq;
        rb     = in.lane[LANE_LAST].rem;
        llen_n = rb + F24_W'(1);
        per_n  = in.lane[LANE_PER].dq[F24_W-1:0];
        // Last complete record: one below the last record unless it ends
        // exactly at the buffer end, never below zero.
        if (llen_n == record_size)
            lfull_n = WIDE_W'(qb);
        else if (qb == '0)
            lfull_n = '0;
        else
            lfull_n = WIDE_W'(qb) - WIDE_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nfirst_reg <= WIDE_W'(qa);
            nlast_reg  <= WIDE_W'(qb);
            nffull_reg <= WIDE_W'(qa) + WIDE_W'(ra != '0);
            nlfull_reg <= lfull_n;
            fpos_reg   <= ra;
            boff_reg   <= (ra != '0) ? (record_size - ra) : '0;
            llen_reg   <= llen_n;
            nlpos_reg  <= LPOS_W'(buffer_size) - LPOS_W'(llen_n);
            per_reg    <= per_n;
            afirst_reg <= 56'(in.lane[LANE_BLK].dq[31:0]) * 56'(per_n);
            alpos_reg  <= 48'(per_n - F24_W'(1)) * 48'(record_size);
        end
    end

    // Stage two: mode select and saturation
    logic [WIDE_W-1:0] f_w, l_w, ff_w, lf_w;
    logic              hit;
    logic              short_buf;

    always_comb
    begin
        short_buf = align_mode && (per_reg == '0);
        if (align_mode)
        begin
            f_w  = WIDE_W'(afirst_reg);
            l_w  = WIDE_W'(afirst_reg) + WIDE_W'(per_reg) - WIDE_W'(1);
            ff_w = f_w;
            lf_w = l_w;
        end
        else
        begin
            f_w  = nfirst_reg;
            l_w  = nlast_reg;
            ff_w = nffull_reg;
            lf_w = nlfull_reg;
        end
        hit = (f_w > Limit) || (l_w > Limit) || (ff_w > Limit) || (lf_w > Limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in.valid;
            out_valid <= v1_reg;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (short_buf)
            begin
                first_record      <= '0;
                last_record       <= '0;
                first_full_record <= '0;
                last_full_record  <= '0;
                first_record_pos  <= '0;
                boundary_offset   <= '0;
                last_record_len   <= '0;
                last_record_pos   <= '0;
                status            <= ST_SHORT;
            end
            else
            begin
                first_record      <= IDX_W'((f_w  > Limit) ? Limit : f_w);
                last_record       <= IDX_W'((l_w  > Limit) ? Limit : l_w);
                first_full_record <= IDX_W'((ff_w > Limit) ? Limit : ff_w);
                last_full_record  <= IDX_W'((lf_w > Limit) ? Limit : lf_w);
                first_record_pos  <= align_mode ? '0 : fpos_reg;
                boundary_offset   <= align_mode ? '0 : boff_reg;
                last_record_len   <= align_mode ? record_size : llen_reg;
                last_record_pos   <= align_mode ? alpos_reg[LPOS_W-1:0] : nlpos_reg;
                status            <= hit ? ST_SAT : ST_OK;
            end
        end
    end

endmodule

// File: rtl/buffer_record_span_calc.sv
// Top level of the buffer record span calculator: configuration registers,
// front end, chain of divider cells and back end. Depends on brsc_pkg.
//
//  channel   direction  tdata / fields                          tuser
//  s_axis    in         block_number[31:0]                      -
//  m_axis    out        record span fields, 296 bits            status[1:0]
//  cfg       in         cfg_addr selects register, cfg_wdata    -
//
// One item per cycle while the output is taken; each item passes through two
// front stages, one cell per quotient bit in the 50-cell divider chain, and
// two back stages. Reset clears only the valid bits and the configuration.
// When the output item is not taken the whole pipeline holds.
module buffer_record_span_calc
    import brsc_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // block_number
    output logic               m_tvalid,
    input  logic               m_tready,
    // first_record, last_record, first_full_record, last_full_record,
    // first_record_pos, boundary_offset, last_record_len, last_record_pos, pad
    output logic [295:0]       m_tdata,
    output logic [1:0]         m_tuser,   // status
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    logic [REM_W-1:0] record_size_reg;
    logic [16:0]      block_size_reg;
    logic [REM_W-1:0] buffer_size_reg;
    logic [15:0]      blocks_per_reg;
    logic             align_mode_reg;
    logic             en;

    // Configuration; zero record size, buffer size and blocks per buffer act as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_size_reg <= REM_W'(1);
            block_size_reg  <= 17'd512;
            buffer_size_reg <= REM_W'(512);
            blocks_per_reg  <= 16'd1;
            align_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RECORD_SIZE: record_size_reg <= (cfg_wdata == '0) ? REM_W'(1) : cfg_wdata;
                REG_BLOCK_SIZE:  block_size_reg  <= cfg_wdata[16:0];
                REG_BUFFER_SIZE: buffer_size_reg <= (cfg_wdata == '0) ? REM_W'(1) : cfg_wdata;
                REG_BLOCKS_PER:  blocks_per_reg  <= (cfg_wdata[15:0] == '0) ? 16'd1
                                                                             : cfg_wdata[15:0];
                REG_ALIGN_MODE:  align_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [N_LANE-1:0][REM_W-1:0] divisor;
    assign divisor[LANE_FIRST] = record_size_reg;
    assign divisor[LANE_LAST]  = record_size_reg;
    assign divisor[LANE_PER]   = record_size_reg;
    assign divisor[LANE_BLK]   = REM_W'(blocks_per_reg);

    cell_t chain [0:DIV_W];

    brsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_tvalid),
        .block_number (s_tdata),
        .block_size   (block_size_reg),
        .buffer_size  (buffer_size_reg),
        .out          (chain[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar g = 0; g < DIV_W; g++)
    begin : g_cell
        brsc_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .divisor (divisor),
            .in      (chain[g]),
            .out     (chain[g+1])
        );
    end

    logic [IDX_W-1:0]  first_record, last_record, first_full_record, last_full_record;
    logic [F24_W-1:0]  first_record_pos, boundary_offset, last_record_len;
    logic [LPOS_W-1:0] last_record_pos;

    brsc_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in                (chain[DIV_W]),
        .record_size       (record_size_reg),
        .buffer_size       (buffer_size_reg),
        .align_mode        (align_mode_reg),
        .out_valid         (m_tvalid),
        .first_record      (first_record),
        .last_record       (last_record),
        .first_full_record (first_full_record),
        .last_full_record  (last_full_record),
        .first_record_pos  (first_record_pos),
        .boundary_offset   (boundary_offset),
        .last_record_len   (last_record_len),
        .last_record_pos   (last_record_pos),
        .status            (m_tuser)
    );

    assign m_tdata = {3'b000, last_record_pos, last_record_len, boundary_offset,
                      first_record_pos, last_full_record, first_full_record,
                      last_record, first_record};

endmodule
